// ===== sv/amach_pkg.sv =====
// shared types, opcodes and constants of the accumulator register machine
package amach_pkg;

  localparam int unsigned REG_WIDTH_DEF = 16;
  localparam int unsigned PC_WIDTH      = 16;
  localparam int unsigned EMIT_WIDTH    = 16;

  localparam logic [PC_WIDTH-1:0] HALT_ADDR = 16'd92;
  localparam logic [PC_WIDTH-1:0] PC_STEP   = 16'd6;

  // register selector codes
  localparam logic [1:0] SEL_A   = 2'd0;
  localparam logic [1:0] SEL_B   = 2'd1;
  localparam logic [1:0] SEL_C   = 2'd2;
  localparam logic [1:0] SEL_IMM = 2'd3;

  typedef enum logic [4:0] {
    OP_MV  = 5'd0,
    OP_RD  = 5'd1,
    OP_MI  = 5'd2,
    OP_AD  = 5'd3,
    OP_SB  = 5'd4,
    OP_MP  = 5'd5,
    OP_JC  = 5'd6,
    OP_JZ  = 5'd7,
    OP_JL  = 5'd8,
    OP_JP  = 5'd9,
    OP_JM  = 5'd10,
    OP_PR  = 5'd11,
    OP_CF  = 5'd12,
    OP_PF  = 5'd13,
    OP_IC  = 5'd14,
    OP_DC  = 5'd15,
    OP_EX  = 5'd16,
    OP_NOP = 5'd17
  } op_e;

  typedef struct packed {
    logic [4:0]  op;
    logic [1:0]  dst_reg;
    logic [1:0]  src_sel;
    logic [15:0] immediate;
    logic [15:0] jump_target;
    logic [15:0] read_value;
  } instr_t;

  typedef struct packed {
    logic [PC_WIDTH-1:0]   next_pc;
    logic                  emit_valid;
    logic                  emit_to_file;
    logic                  emit_is_char;
    logic [EMIT_WIDTH-1:0] emit_value;
    logic                  file_clear;
    logic                  halted;
  } result_t;

  typedef struct packed {
    logic       we;
    logic [1:0] sel;
  } wb_ctl_t;

endpackage

// ===== sv/amach_exec.sv =====
// combinational decode, alu and branch logic for one instruction
module amach_exec #(
  parameter int unsigned REG_WIDTH = amach_pkg::REG_WIDTH_DEF
) (
  input  amach_pkg::instr_t  instr_i,
  input  logic [REG_WIDTH-1:0] reg_a_i,
  input  logic [REG_WIDTH-1:0] reg_b_i,
  input  logic [REG_WIDTH-1:0] reg_c_i,
  input  logic [15:0]          pc_i,
  output logic [15:0]          pc_o,
  output amach_pkg::wb_ctl_t wb_ctl_o,
  output logic [REG_WIDTH-1:0] wb_data_o,
  output amach_pkg::result_t res_o
);
  import amach_pkg::*;

  logic                 dst_ok;
  logic                 src_is_imm;
  logic                 halted_now;
  logic [REG_WIDTH-1:0] dst_val;
  logic [REG_WIDTH-1:0] src_val;
  logic [31:0]          imm_ext;
  logic [31:0]          rdv_ext;
  logic [31:0]          dst_ext;
  logic [REG_WIDTH-1:0] imm_w;
  logic [REG_WIDTH-1:0] rdv_w;
  logic [REG_WIDTH-1:0] alu_op;
  logic [REG_WIDTH-1:0] sum_w;
  logic [REG_WIDTH-1:0] diff_w;
  logic [REG_WIDTH-1:0] prod_w;
  logic [REG_WIDTH-1:0] one_w;
  logic [15:0]          pc_step;
  logic                 c_zero;
  logic                 c_neg;

  assign dst_ok     = (instr_i.dst_reg != SEL_IMM);
  assign src_is_imm = (instr_i.src_sel == SEL_IMM);
  assign halted_now = (pc_i == HALT_ADDR);
  assign pc_step    = pc_i + PC_STEP;

  assign imm_ext = 32'(signed'(instr_i.immediate));
  assign rdv_ext = 32'(signed'(instr_i.read_value));
  assign imm_w   = imm_ext[REG_WIDTH-1:0];
  assign rdv_w   = rdv_ext[REG_WIDTH-1:0];
  assign one_w   = {{(REG_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    unique case (instr_i.dst_reg)
      SEL_A:   dst_val = reg_a_i;
      SEL_B:   dst_val = reg_b_i;
      SEL_C:   dst_val = reg_c_i;
      default: dst_val = '0;
    endcase
  end

  always_comb begin
    unique case (instr_i.src_sel)
      SEL_A:   src_val = reg_a_i;
      SEL_B:   src_val = reg_b_i;
      SEL_C:   src_val = reg_c_i;
      default: src_val = '0;
    endcase
  end

  assign dst_ext = 32'(dst_val);

  // immediate form works on A, register form takes the dst operand
  assign alu_op = src_is_imm ? imm_w : dst_val;
  assign sum_w  = reg_a_i + alu_op;
  assign diff_w = reg_a_i - alu_op;
  assign prod_w = reg_a_i * alu_op;

  assign c_zero = (reg_c_i == '0);
  assign c_neg  = reg_c_i[REG_WIDTH-1];

  always_comb begin
    pc_o                = halted_now ? pc_i : pc_step;
    wb_ctl_o.we         = 1'b0;
    wb_ctl_o.sel        = instr_i.dst_reg;
    wb_data_o           = '0;
    res_o.emit_valid    = 1'b0;
    res_o.emit_to_file  = 1'b0;
    res_o.emit_is_char  = 1'b0;
    res_o.emit_value    = '0;
    res_o.file_clear    = 1'b0;

    if (!halted_now) begin
      unique case (op_e'(instr_i.op))
        OP_MV: begin
          wb_ctl_o.we = dst_ok && !src_is_imm;
          wb_data_o   = src_val;
        end
        OP_RD: begin
          wb_ctl_o.we = dst_ok;
          wb_data_o   = rdv_w;
        end
        OP_MI: begin
          wb_ctl_o.we = dst_ok;
          wb_data_o   = imm_w;
        end
        OP_AD: begin
          wb_ctl_o.we  = src_is_imm || dst_ok;
          wb_ctl_o.sel = src_is_imm ? SEL_A : instr_i.dst_reg;
          wb_data_o    = sum_w;
        end
        OP_SB: begin
          wb_ctl_o.we  = src_is_imm || dst_ok;
          wb_ctl_o.sel = src_is_imm ? SEL_A : instr_i.dst_reg;
          wb_data_o    = diff_w;
        end
        OP_MP: begin
          wb_ctl_o.we  = src_is_imm || dst_ok;
          wb_ctl_o.sel = SEL_A;
          wb_data_o    = prod_w;
        end
        OP_JC: if (!c_zero) pc_o = instr_i.jump_target;
        OP_JZ: if (c_zero) pc_o = instr_i.jump_target;
        OP_JL: if (c_neg) pc_o = instr_i.jump_target;
        OP_JP: pc_o = instr_i.jump_target;
        OP_JM: if (!c_zero && !c_neg) pc_o = instr_i.jump_target;
        OP_PR: begin
          res_o.emit_valid = dst_ok;
          res_o.emit_value = dst_ok ? dst_ext[15:0] : '0;
        end
        OP_CF: res_o.file_clear = 1'b1;
        OP_PF: begin
          if (src_is_imm) begin
            res_o.emit_valid   = 1'b1;
            res_o.emit_to_file = 1'b1;
            res_o.emit_is_char = 1'b1;
            res_o.emit_value   = {8'h00, instr_i.immediate[7:0]};
          end else if (dst_ok) begin
            res_o.emit_valid   = 1'b1;
            res_o.emit_to_file = 1'b1;
            res_o.emit_value   = dst_ext[15:0];
          end
        end
        OP_IC: begin
          wb_ctl_o.we = dst_ok;
          wb_data_o   = reg_a_i + one_w;
        end
        OP_DC: begin
          wb_ctl_o.we = dst_ok;
          wb_data_o   = dst_val - one_w;
        end
        OP_EX: pc_o = HALT_ADDR;
        OP_NOP: ;
        default: ;
      endcase
    end

    res_o.next_pc = pc_o;
    res_o.halted  = (pc_o == HALT_ADDR);
  end

endmodule

// ===== sv/accumulator_register_machine_step.sv =====
// top level of the accumulator register machine: input word register, state and result register
// Executes one pre-decoded instruction per accepted input word on a machine with three
// wrapping registers A, B, C (REG_WIDTH bits, reset A=0 B=1 C=0) and a 16-bit program
// counter (reset 0) that advances by 6 per instruction; EX parks it at 92, after which
// every word is ignored and reports next_pc 92 with halted set. Each input word gives
// exactly one result word. Throughput is one instruction per clock while the result
// channel is not stalled: the word sits in an input register, the decode/alu/branch
// logic resolves it combinationally against the architectural registers, and the result
// lands in an output register while the state is updated at the same edge.
// The input register keeps taking words while a finished result waits; stall only
// propagates back when both the input and result registers are full.
module accumulator_register_machine_step #(
  parameter int unsigned REG_WIDTH = amach_pkg::REG_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // instruction word channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  op_i,
  input  logic [1:0]  dst_reg_i,
  input  logic [1:0]  src_sel_i,
  input  logic signed [15:0] immediate_i,
  input  logic [15:0] jump_target_i,
  input  logic signed [15:0] read_value_i,

  // result word channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] next_pc_o,
  output logic        emit_valid_o,
  output logic        emit_to_file_o,
  output logic        emit_is_char_o,
  output logic signed [15:0] emit_value_o,
  output logic        file_clear_o,
  output logic        halted_o
);
  import amach_pkg::*;

  // input word register
  logic    in_valid_q, in_valid_d;
  instr_t  instr_q;
  logic    in_accept;

  // result word register
  logic    out_valid_q, out_valid_d;
  result_t res_q;

  // architectural state
  logic [REG_WIDTH-1:0] reg_a_q, reg_b_q, reg_c_q;
  logic [15:0]          pc_q;

  // execute stage outputs
  logic [15:0]          pc_next;
  wb_ctl_t              wb_ctl;
  logic [REG_WIDTH-1:0] wb_data;
  result_t              res_next;
  logic                 exec_fire;

  // the held word executes once the result register is free or draining
  assign exec_fire  = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !exec_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (exec_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      instr_q.op          <= op_i;
      instr_q.dst_reg     <= dst_reg_i;
      instr_q.src_sel     <= src_sel_i;
      instr_q.immediate   <= immediate_i;
      instr_q.jump_target <= jump_target_i;
      instr_q.read_value  <= read_value_i;
    end
    if (exec_fire) begin
      res_q <= res_next;
    end
  end

  amach_exec #(
    .REG_WIDTH (REG_WIDTH)
  ) u_exec (
    .instr_i   (instr_q),
    .reg_a_i   (reg_a_q),
    .reg_b_i   (reg_b_q),
    .reg_c_i   (reg_c_q),
    .pc_i      (pc_q),
    .pc_o      (pc_next),
    .wb_ctl_o  (wb_ctl),
    .wb_data_o (wb_data),
    .res_o     (res_next)
  );

  // state write-back, committed in the same edge as the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_a_q <= '0;
      reg_b_q <= {{(REG_WIDTH-1){1'b0}}, 1'b1};
      reg_c_q <= '0;
      pc_q    <= '0;
    end else if (exec_fire) begin
      pc_q <= pc_next;
      if (wb_ctl.we) begin
        unique case (wb_ctl.sel)
          SEL_A:   reg_a_q <= wb_data;
          SEL_B:   reg_b_q <= wb_data;
          SEL_C:   reg_c_q <= wb_data;
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = res_q.next_pc;
  assign emit_valid_o   = res_q.emit_valid;
  assign emit_to_file_o = res_q.emit_to_file;
  assign emit_is_char_o = res_q.emit_is_char;
  assign emit_value_o   = res_q.emit_value;
  assign file_clear_o   = res_q.file_clear;
  assign halted_o       = res_q.halted;

`ifndef SYNTH
  // once parked at the halt address the machine never leaves it
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == HALT_ADDR) |=> (pc_q == HALT_ADDR))
    else $error("program counter left the halt address");

  // architectural state only moves when a word executes
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec_fire |=> $stable({reg_a_q, reg_b_q, reg_c_q, pc_q}))
    else $error("state changed without an executed word");

  // an executed word always shows up as a result next cycle
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_valid_q)
    else $error("executed word produced no result");

  // emit side fields are clean when nothing is emitted
  a_emit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.emit_valid) |->
      (!res_q.emit_to_file && !res_q.emit_is_char && res_q.emit_value == '0))
    else $error("emit fields set without emit_valid");

  // halted flag agrees with the reported program counter
  a_halt_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.halted == (res_q.next_pc == HALT_ADDR)))
    else $error("halted flag disagrees with next_pc");
`endif

endmodule
